/* rtl/core/lru_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types for the layer radiance update pipeline.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Control flags that travel with each beat down the pipeline and divider chain
  typedef struct packed {
    logic valid;     // beat present in this stage
    logic lin;       // linear-in-tau source for this beat
    logic up;        // upward propagation
    logic clamp;     // (one - tx) >= tau, ratio forced to one
    logic taylor;    // tau at or below the series limit
    logic tau_zero;  // tau is zero
  } lru_ctl_t;

endpackage

/* rtl/core/layer_radiance_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layer_radiance_update
// Radiance across one layer: I_out = I_in*tx + source, isothermal or
// linear-in-tau source, saturating output. Fully pipelined.
// ----------------------------------------------------------------------------
//   channel | ports                               | handshake
//   --------+-------------------------------------+---------------------------
//   input   | start, busy, in_*                   | beat on start & !busy
//   result  | out_valid, out_radiance_out, out_sat| one-cycle strobe
//   config  | cfg_valid, cfg_ready, cfg_linear_.. | beat on valid & ready
//
// One beat per cycle; busy stays low. Each beat passes through the restoring
// divider chain, one cell per quotient bit, between input and result stages.
// Synchronous active-low reset empties the pipeline and clears the mode.
// The result side has no backpressure; cfg_ready is always high.
// ----------------------------------------------------------------------------
module layer_radiance_update #(
  parameter int RADIANCE_BITS = 40,
  parameter int FRACTION_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [RADIANCE_BITS-1:0]   in_radiance_in,
  input  logic [FRACTION_BITS+7:0]   in_optical_depth,
  input  logic [FRACTION_BITS:0]     in_transmittance,
  input  logic [RADIANCE_BITS-1:0]   in_planck_this_layer,
  input  logic [RADIANCE_BITS-1:0]   in_planck_adjacent_layer,
  input  logic                       in_direction_up,
  input  logic                       in_bottom_layer,
  output logic                       out_valid,
  output logic [RADIANCE_BITS-1:0]   out_radiance_out,
  output logic                       out_saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_linear_in_tau
);

  localparam int R   = RADIANCE_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int TW  = F + 8;
  localparam int RW  = TW + 1;
  localparam int CW  = F + 1;
  localparam int TS  = F - 8;
  localparam int BW  = 3 * R + CW;
  localparam int SW  = BW + 2 * CW;
  localparam int H   = (R + 1) / 2;
  localparam int HL  = R - H;
  localparam int LAT = F + 7;

  localparam longint unsigned ONE_L = 64'd1 << F;
  localparam logic [CW-1:0] ONE_FX       = {1'b1, {F{1'b0}}};
  localparam logic [F-1:0]  HALF_FX      = {1'b1, {(F-1){1'b0}}};
  localparam logic [TW-1:0] TAYLOR_LIMIT = TW'((ONE_L * 2 + 500) / 1000);
  localparam logic [F-1:0]  SIXTH_FX     = F'((ONE_L + 3) / 6);
  localparam logic [F-1:0]  THIRD_FX     = F'((ONE_L + 1) / 3);
  localparam logic [TS:0]   RECIP3       = (TS+1)'(((64'd1 << (TS + 1)) + 2) / 3);
  localparam logic [R-1:0]  RAD_MAX      = {R{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic lin_mode_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      lin_mode_r <= cfg_linear_in_tau;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage
  // --------------------------------------------------------------------------
  logic [CW-1:0]     txc, d_in;
  lru_pkg::lru_ctl_t ctl_in;

  assign txc = (in_transmittance > ONE_FX) ? ONE_FX : in_transmittance;
  assign d_in = ONE_FX - txc;

  always_comb begin
    ctl_in          = '0;
    ctl_in.valid    = start && !busy;
    ctl_in.lin      = lin_mode_r && !in_bottom_layer;
    ctl_in.up       = in_direction_up;
    ctl_in.clamp    = (TW'(d_in) >= in_optical_depth);
    ctl_in.taylor   = (in_optical_depth <= TAYLOR_LIMIT);
    ctl_in.tau_zero = (in_optical_depth == '0);
  end

  lru_pkg::lru_ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  logic [BW-1:0]     s1_base_r, s2_base_r, s3_base_r, s4_base_r;
  logic [TW-1:0]     s1_tau_r, s2_tau_r, s3_tau_r, s4_tau_r;
  logic [CW-1:0]     s1_d_r, s2_d_r, s3_d_r, s4_d_r;
  logic [2*TS:0]     prod3_r;
  logic [F-1:0]      av_r;
  logic [TS+F-1:0]   pu_r, pv_r, mu_r, mv_r;

  // series terms, valid only while tau is small
  logic [TS-1:0]   ts1, ts2, ts3;
  logic [F-1:0]    au, bu, bv;
  logic [2*TS:0]   prod3_nxt;
  logic [F-1:0]    av_nxt;
  logic [TS+F-1:0] pu_nxt, pv_nxt, mu_nxt, mv_nxt;

  assign ts1       = s1_tau_r[TS-1:0];
  assign prod3_nxt = (2*TS+1)'(ts1 >> 3) * (2*TS+1)'(RECIP3);
  assign av_nxt    = THIRD_FX - F'(ts1 >> 3);

  assign ts2    = s2_tau_r[TS-1:0];
  assign au     = SIXTH_FX - F'(prod3_r[2*TS:TS+1]);
  assign pu_nxt = (TS+F)'(ts2) * (TS+F)'(au);
  assign pv_nxt = (TS+F)'(ts2) * (TS+F)'(av_r);

  assign ts3    = s3_tau_r[TS-1:0];
  assign bu     = HALF_FX - F'(pu_r[TS+F-1:F]);
  assign bv     = HALF_FX - F'(pv_r[TS+F-1:F]);
  assign mu_nxt = (TS+F)'(ts3) * (TS+F)'(bu);
  assign mv_nxt = (TS+F)'(ts3) * (TS+F)'(bv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
    end else begin
      s1_ctl_r <= ctl_in;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_base_r <= {in_radiance_in, in_planck_this_layer, in_planck_adjacent_layer, txc};
    s1_tau_r  <= in_optical_depth;
    s1_d_r    <= d_in;
    s2_base_r <= s1_base_r;
    s2_tau_r  <= s1_tau_r;
    s2_d_r    <= s1_d_r;
    prod3_r   <= prod3_nxt;
    av_r      <= av_nxt;
    s3_base_r <= s2_base_r;
    s3_tau_r  <= s2_tau_r;
    s3_d_r    <= s2_d_r;
    pu_r      <= pu_nxt;
    pv_r      <= pv_nxt;
    s4_base_r <= s3_base_r;
    s4_tau_r  <= s3_tau_r;
    s4_d_r    <= s3_d_r;
    mu_r      <= mu_nxt;
    mv_r      <= mv_nxt;
  end

  // --------------------------------------------------------------------------
  // Divider chain: w = (one - tx) * 2^F / tau, one bit per cell
  // --------------------------------------------------------------------------
  lru_pkg::lru_ctl_t ch_ctl  [0:F];
  logic [RW-1:0]     ch_rem  [0:F];
  logic [F-1:0]      ch_quo  [0:F];
  logic [TW-1:0]     ch_tau  [0:F];
  logic [SW-1:0]     ch_side [0:F];

  assign ch_ctl[0]  = s4_ctl_r;
  assign ch_rem[0]  = RW'(s4_d_r);
  assign ch_quo[0]  = '0;
  assign ch_tau[0]  = s4_tau_r;
  assign ch_side[0] = {s4_base_r, CW'(mu_r[TS+F-1:F]), CW'(mv_r[TS+F-1:F])};

  for (genvar k = 0; k < F; k++) begin : g_cell
    lru_div_cell #(
      .TW(TW), .RW(RW), .QW(F), .SW(SW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (ch_ctl[k]),
      .in_rem  (ch_rem[k]),
      .in_quo  (ch_quo[k]),
      .in_tau  (ch_tau[k]),
      .in_side (ch_side[k]),
      .out_ctl (ch_ctl[k+1]),
      .out_rem (ch_rem[k+1]),
      .out_quo (ch_quo[k+1]),
      .out_tau (ch_tau[k+1]),
      .out_side(ch_side[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Coefficient select and split products
  // --------------------------------------------------------------------------
  lru_pkg::lru_ctl_t ce_ctl;
  logic [BW-1:0]     ce_base;
  logic [CW-1:0]     ce_ut, ce_vt, ce_tx, w_fx, u_fx, v_fx, u_sel, v_sel;
  logic [R-1:0]      ce_rin, ce_bthis, ce_badj;
  logic [R-1:0]      pa [0:2];
  logic [CW-1:0]     pc [0:2];

  assign ce_ctl   = ch_ctl[F];
  assign ce_base  = ch_side[F][SW-1:2*CW];
  assign ce_ut    = ch_side[F][2*CW-1:CW];
  assign ce_vt    = ch_side[F][CW-1:0];
  assign ce_rin   = ce_base[BW-1 -: R];
  assign ce_bthis = ce_base[BW-R-1 -: R];
  assign ce_badj  = ce_base[BW-2*R-1 -: R];
  assign ce_tx    = ce_base[CW-1:0];

  assign w_fx  = ce_ctl.clamp ? ONE_FX : {1'b0, ch_quo[F]};
  assign u_fx  = ONE_FX - w_fx;
  assign v_fx  = (w_fx > ce_tx) ? (w_fx - ce_tx) : '0;
  assign u_sel = ce_ctl.taylor ? ce_ut : u_fx;
  assign v_sel = ce_ctl.taylor ? ce_vt : v_fx;

  always_comb begin
    pa[0] = ce_rin;
    pc[0] = ce_tx;
    if (ce_ctl.lin) begin
      pa[1] = ce_ctl.up ? ce_badj : ce_bthis;
      pc[1] = u_sel;
      pa[2] = ce_ctl.up ? ce_bthis : ce_badj;
      pc[2] = v_sel;
    end else begin
      pa[1] = ce_bthis;
      pc[1] = ce_ctl.tau_zero ? '0 : (ONE_FX - ce_tx);
      pa[2] = ce_bthis;
      pc[2] = '0;
    end
  end

  logic             p1_valid_r, p2_valid_r, out_valid_r;
  logic [H+CW-1:0]  plo_r [0:2];
  logic [HL+CW-1:0] phi_r [0:2];
  logic [R-1:0]     psc_r [0:2];
  logic [R+CW-1:0]  pfull [0:2];

  for (genvar j = 0; j < 3; j++) begin : g_prod
    always_ff @(posedge clk) begin
      plo_r[j] <= (H+CW)'(pa[j][H-1:0]) * (H+CW)'(pc[j]);
      phi_r[j] <= (HL+CW)'(pa[j][R-1:H]) * (HL+CW)'(pc[j]);
      psc_r[j] <= pfull[j][R+F-1:F];
    end
    assign pfull[j] = {phi_r[j], {H{1'b0}}} + (R+CW)'(plo_r[j]);
  end

  // --------------------------------------------------------------------------
  // Sum and saturate
  // --------------------------------------------------------------------------
  logic [R+1:0]  sum;
  logic [R-1:0]  rad_r;
  logic          sat_r;

  assign sum = (R+2)'(psc_r[0]) + (R+2)'(psc_r[1]) + (R+2)'(psc_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= ce_ctl.valid;
      p2_valid_r  <= p1_valid_r;
      out_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= (sum[R+1:R] != 2'b00);
    rad_r <= (sum[R+1:R] != 2'b00) ? RAD_MAX : sum[R-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_radiance_out = rad_r;
  assign out_saturated    = sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat did not produce a result after the pipeline latency");

  a_sat_max : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> (out_radiance_out == RAD_MAX))
    else $error("saturated result is not the full-scale radiance");

endmodule

/* rtl/core/lru_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_div_cell
// One restoring division step: develops one quotient bit per cell and
// hands remainder, partial quotient, divisor and sideband to the next cell.
// ----------------------------------------------------------------------------
module lru_div_cell #(
  parameter int TW = 32,  // divisor width
  parameter int RW = 33,  // remainder width
  parameter int QW = 24,  // quotient width
  parameter int SW = 8    // sideband width
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lru_pkg::lru_ctl_t in_ctl,
  input  logic [RW-1:0]    in_rem,
  input  logic [QW-1:0]    in_quo,
  input  logic [TW-1:0]    in_tau,
  input  logic [SW-1:0]    in_side,
  output lru_pkg::lru_ctl_t out_ctl,
  output logic [RW-1:0]    out_rem,
  output logic [QW-1:0]    out_quo,
  output logic [TW-1:0]    out_tau,
  output logic [SW-1:0]    out_side
);

  lru_pkg::lru_ctl_t ctl_r;
  logic [RW-1:0] rem_r, rem_nxt, rem_sh, tau_ext;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [TW-1:0] tau_r;
  logic [SW-1:0] side_r;
  logic          ge;

  assign rem_sh  = {in_rem[RW-2:0], 1'b0};
  assign tau_ext = RW'(in_tau);
  assign ge      = (rem_sh >= tau_ext);
  assign rem_nxt = ge ? (rem_sh - tau_ext) : rem_sh;
  assign quo_nxt = {in_quo[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    tau_r  <= in_tau;
    side_r <= in_side;
  end

  assign out_ctl  = ctl_r;
  assign out_rem  = rem_r;
  assign out_quo  = quo_r;
  assign out_tau  = tau_r;
  assign out_side = side_r;

endmodule
